// File: hw/rtl/ibw_pkg.sv
// shared types, widths and helpers of the inverse bilinear weights block
package ibw_pkg;

    localparam int COORD_W   = 16;
    localparam int FRAC_Q    = 14;
    localparam int Q14_ONE   = 16384;
    localparam int Q_MAX     = 32767;
    localparam int Q_MIN_MAG = 32768;
    localparam int SAT_MAG_W = 21;
    localparam int DIFF_W    = 17;
    localparam int GX_W      = 18;
    localparam int K0_W      = 36;
    localparam int K1_W      = 37;
    localparam int K2_W      = 36;
    localparam int PARA_LIM  = 256;
    localparam int DISC_W    = 74;
    localparam int ROOT_W    = 38;
    localparam int VNUM_W    = 40;
    localparam int VDEN_W    = 38;
    localparam int UNUM_W    = 36;
    localparam int UDEN_W    = 36;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t tl_x;
        coord_t tl_y;
        coord_t tr_x;
        coord_t tr_y;
        coord_t bl_x;
        coord_t bl_y;
        coord_t br_x;
        coord_t br_y;
    } ibw_in_t;

    typedef struct packed {
        coord_t weight_u;
        coord_t weight_v;
        coord_t w_top_left;
        coord_t w_top_right;
        coord_t w_bottom_left;
        coord_t w_bottom_right;
        logic   degenerate;
    } ibw_out_t;

    // cross products and edge terms of one quad
    typedef struct packed {
        logic signed [K2_W-1:0]   k2;
        logic signed [K1_W-1:0]   k1;
        logic signed [K0_W-1:0]   k0;
        logic                     para;
        logic                     neg;
        logic signed [DIFF_W-1:0] hx;
        logic signed [DIFF_W-1:0] fx;
        logic signed [DIFF_W-1:0] ex;
        logic signed [GX_W-1:0]   gx;
    } quad_t;

    // terms needed to solve for u
    typedef struct packed {
        logic signed [DIFF_W-1:0] hx;
        logic signed [DIFF_W-1:0] fx;
        logic signed [DIFF_W-1:0] ex;
        logic signed [GX_W-1:0]   gx;
        logic                     para;
        logic                     neg;
    } ucoef_t;

    // both v candidates and flags
    typedef struct packed {
        coord_t va;
        coord_t vb;
        logic   vzero;
        logic   para;
        logic   neg;
    } vpair_t;

    // signed 16 bit result from sign and magnitude, saturated
    function automatic coord_t sat_q14(input logic neg, input logic [SAT_MAG_W-1:0] mag);
        coord_t r;
        if (!neg) begin
            r = (mag > SAT_MAG_W'(Q_MAX)) ? COORD_W'(Q_MAX) : mag[COORD_W-1:0];
        end
        else begin
            r = (mag > SAT_MAG_W'(Q_MIN_MAG)) ? COORD_W'(-Q_MIN_MAG) : -mag[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/ibw_if.sv
// valid/ready channel interfaces for quad requests and weight results
interface ibw_in_if;
    import ibw_pkg::*;
    logic    valid;
    logic    ready;
    ibw_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ibw_out_if;
    import ibw_pkg::*;
    logic     valid;
    logic     ready;
    ibw_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/inverse_bilinear_weights_top.sv
// Inverse bilinear weights: finds (u, v) of a point inside a quad and the four corner weights.
// One transaction is taken every cycle unless the output stalls. Stages: 6 of cross products
// and discriminant, 38 for the square root (one root bit each), a register for the v
// numerators, 20 for the v divider, 2 for the u terms, 20 for the u divider (one quotient
// bit per inner stage) and 3 for root selection and weights. All stages move on one enable,
// so a result held on the output holds all stages and the input alike; no transaction is lost.
module inverse_bilinear_weights_top
    import ibw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ibw_in_if.sink    quad,
    ibw_out_if.source weights
);
    localparam int FXV_W = DIFF_W + COORD_W;
    localparam int GXV_W = GX_W + COORD_W;

    logic en;
    logic w_valid;
    ibw_out_t w_data;

    logic              f_valid;
    quad_t             f_quad;
    logic [DISC_W-1:0] f_disc;

    logic              s_valid;
    quad_t             s_quad;
    logic [ROOT_W-1:0] s_root;

    logic                     v0_valid_reg;
    logic signed [VNUM_W-1:0] numa_reg, numb_reg;
    logic signed [VDEN_W-1:0] dena_reg, denb_reg;
    ucoef_t                   coef_reg, coef_next;

    logic   vd_valid;
    ucoef_t vd_coef;
    coord_t va, vb;
    logic   vza;

    logic                    u1_valid_reg, u2_valid_reg;
    logic signed [FXV_W-1:0] fxva_reg, fxvb_reg;
    logic signed [GXV_W-1:0] gxva_reg, gxvb_reg;
    logic signed [DIFF_W-1:0] hx_reg, ex_reg;
    vpair_t                  vp1_reg, vp2_reg, vp_next;
    logic signed [UNUM_W-1:0] una_reg, unb_reg;
    logic signed [UDEN_W-1:0] uda_reg, udb_reg;

    logic   ud_valid;
    vpair_t ud_vp;
    coord_t ua, ub;
    logic   za, zb;

    assign en           = !w_valid || weights.ready;
    assign quad.ready   = en;
    assign weights.valid = w_valid;
    assign weights.data  = w_data;

    ibw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (quad.valid),
        .in_data   (quad.data),
        .out_valid (f_valid),
        .out_quad  (f_quad),
        .out_disc  (f_disc)
    );

    ibw_sqrt #(.side_t(quad_t)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_quad),
        .in_rad    (f_disc),
        .out_valid (s_valid),
        .out_side  (s_quad),
        .out_root  (s_root)
    );

    always_comb
    begin
        coef_next.hx   = s_quad.hx;
        coef_next.fx   = s_quad.fx;
        coef_next.ex   = s_quad.ex;
        coef_next.gx   = s_quad.gx;
        coef_next.para = s_quad.para;
        coef_next.neg  = s_quad.neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_valid_reg <= 1'b0;
            u1_valid_reg <= 1'b0;
            u2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_valid_reg <= s_valid;
            u1_valid_reg <= vd_valid;
            u2_valid_reg <= u1_valid_reg;
        end
    end

    // candidate numerators and divisors for v
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_reg <= coef_next;
            numb_reg <= -VNUM_W'(s_quad.k1) + $signed(VNUM_W'(s_root));
            denb_reg <= VDEN_W'(s_quad.k2) <<< 1;
            if (s_quad.para)
            begin
                numa_reg <= -VNUM_W'(s_quad.k0);
                dena_reg <= VDEN_W'(s_quad.k1);
            end
            else
            begin
                numa_reg <= -VNUM_W'(s_quad.k1) - $signed(VNUM_W'(s_root));
                dena_reg <= VDEN_W'(s_quad.k2) <<< 1;
            end
        end
    end

    ibw_div #(.NUM_W(VNUM_W), .DEN_W(VDEN_W), .side_t(ucoef_t)) u_vdiv_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_valid_reg),
        .in_side   (coef_reg),
        .in_num    (numa_reg),
        .in_den    (dena_reg),
        .out_valid (vd_valid),
        .out_side  (vd_coef),
        .out_quo   (va),
        .out_zero  (vza)
    );

    ibw_div #(.NUM_W(VNUM_W), .DEN_W(VDEN_W), .side_t(logic)) u_vdiv_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_valid_reg),
        .in_side   (1'b0),
        .in_num    (numb_reg),
        .in_den    (denb_reg),
        .out_valid (),
        .out_side  (),
        .out_quo   (vb),
        .out_zero  ()
    );

    always_comb
    begin
        vp_next.va    = va;
        vp_next.vb    = vb;
        vp_next.vzero = vza;
        vp_next.para  = vd_coef.para;
        vp_next.neg   = vd_coef.neg;
    end

    // numerator and divisor of u for both candidates
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fxva_reg <= vd_coef.fx * va;
            gxva_reg <= vd_coef.gx * va;
            fxvb_reg <= vd_coef.fx * vb;
            gxvb_reg <= vd_coef.gx * vb;
            hx_reg   <= vd_coef.hx;
            ex_reg   <= vd_coef.ex;
            vp1_reg  <= vp_next;
            una_reg  <= (UNUM_W'(hx_reg) <<< FRAC_Q) - UNUM_W'(fxva_reg);
            unb_reg  <= (UNUM_W'(hx_reg) <<< FRAC_Q) - UNUM_W'(fxvb_reg);
            uda_reg  <= (UDEN_W'(ex_reg) <<< FRAC_Q) + UDEN_W'(gxva_reg);
            udb_reg  <= (UDEN_W'(ex_reg) <<< FRAC_Q) + UDEN_W'(gxvb_reg);
            vp2_reg  <= vp1_reg;
        end
    end

    ibw_div #(.NUM_W(UNUM_W), .DEN_W(UDEN_W), .side_t(vpair_t)) u_udiv_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (u2_valid_reg),
        .in_side   (vp2_reg),
        .in_num    (una_reg),
        .in_den    (uda_reg),
        .out_valid (ud_valid),
        .out_side  (ud_vp),
        .out_quo   (ua),
        .out_zero  (za)
    );

    ibw_div #(.NUM_W(UNUM_W), .DEN_W(UDEN_W), .side_t(logic)) u_udiv_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (u2_valid_reg),
        .in_side   (1'b0),
        .in_num    (unb_reg),
        .in_den    (udb_reg),
        .out_valid (),
        .out_side  (),
        .out_quo   (ub),
        .out_zero  (zb)
    );

    ibw_weights u_weights (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ud_valid),
        .in_vp     (ud_vp),
        .in_ua     (ua),
        .in_za     (za),
        .in_ub     (ub),
        .in_zb     (zb),
        .out_valid (w_valid),
        .out_data  (w_data)
    );

endmodule

// File: hw/rtl/ibw_front.sv
// edge vectors, cross products and discriminant, six register stages
module ibw_front
    import ibw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  ibw_in_t           in_data,
    output logic              out_valid,
    output quad_t             out_quad,
    output logic [DISC_W-1:0] out_disc
);
    localparam int PG_W  = GX_W + DIFF_W;
    localparam int PE_W  = 2 * DIFF_W;
    localparam int SQ_SP = 19;
    localparam int QQ_SP = 18;

    typedef struct packed {
        logic signed [DIFF_W-1:0] ex, ey, fx, fy, hx, hy;
        logic signed [GX_W-1:0]   gx, gy;
    } diff_t;

    logic [5:0] valid_reg;

    diff_t d1_next, d1_reg, d2_reg;
    logic signed [PG_W-1:0] gxfy_reg, gyfx_reg, hxgy_reg, hygx_reg;
    logic signed [PE_W-1:0] exfy_reg, eyfx_reg, hxey_reg, hyex_reg;
    quad_t q3_next, q3_reg, q4_next, q4_reg, q5_reg;
    logic [K1_W-1:0] mk1;
    logic [K0_W-1:0] mk0;
    logic [K2_W-1:0] mk2;
    logic [K1_W+SQ_SP-1:0] sqlo_reg;
    logic [2*K1_W-SQ_SP-1:0] sqhi_reg;
    logic [K0_W+QQ_SP-1:0] qlo_reg;
    logic [K0_W+K2_W-QQ_SP-1:0] qhi_reg;
    logic sgn4_reg, sgn5_reg;
    logic [DISC_W-1:0] sq_next, sq_reg, qq_next, qq_reg, disc_next, disc_reg;
    logic neg_next;
    quad_t q6_next, q6_reg;

    always_comb
    begin
        d1_next.ex = DIFF_W'(in_data.tr_x) - DIFF_W'(in_data.tl_x);
        d1_next.ey = DIFF_W'(in_data.tr_y) - DIFF_W'(in_data.tl_y);
        d1_next.fx = DIFF_W'(in_data.bl_x) - DIFF_W'(in_data.tl_x);
        d1_next.fy = DIFF_W'(in_data.bl_y) - DIFF_W'(in_data.tl_y);
        d1_next.hx = DIFF_W'(in_data.point_x) - DIFF_W'(in_data.tl_x);
        d1_next.hy = DIFF_W'(in_data.point_y) - DIFF_W'(in_data.tl_y);
        d1_next.gx = GX_W'(in_data.tl_x) - GX_W'(in_data.tr_x)
                   + GX_W'(in_data.br_x) - GX_W'(in_data.bl_x);
        d1_next.gy = GX_W'(in_data.tl_y) - GX_W'(in_data.tr_y)
                   + GX_W'(in_data.br_y) - GX_W'(in_data.bl_y);
    end

    always_comb
    begin
        q3_next      = '0;
        q3_next.k2   = K2_W'(gxfy_reg) - K2_W'(gyfx_reg);
        q3_next.k1   = K1_W'(exfy_reg) - K1_W'(eyfx_reg) + K1_W'(hxgy_reg) - K1_W'(hygx_reg);
        q3_next.k0   = K0_W'(hxey_reg) - K0_W'(hyex_reg);
        q3_next.hx   = d2_reg.hx;
        q3_next.fx   = d2_reg.fx;
        q3_next.ex   = d2_reg.ex;
        q3_next.gx   = d2_reg.gx;
    end

    always_comb
    begin
        mk1 = q3_reg.k1[K1_W-1] ? K1_W'(-q3_reg.k1) : K1_W'(q3_reg.k1);
        mk0 = q3_reg.k0[K0_W-1] ? K0_W'(-q3_reg.k0) : K0_W'(q3_reg.k0);
        mk2 = q3_reg.k2[K2_W-1] ? K2_W'(-q3_reg.k2) : K2_W'(q3_reg.k2);
        q4_next      = q3_reg;
        q4_next.para = (q3_reg.k2 > -PARA_LIM) && (q3_reg.k2 < PARA_LIM);
    end

    always_comb
    begin
        sq_next = DISC_W'(sqlo_reg) + (DISC_W'(sqhi_reg) << SQ_SP);
        qq_next = (DISC_W'(qlo_reg) + (DISC_W'(qhi_reg) << QQ_SP)) << 2;
    end

    always_comb
    begin
        neg_next = 1'b0;
        if (sgn5_reg)
        begin
            disc_next = sq_reg + qq_reg;
        end
        else if (sq_reg < qq_reg)
        begin
            neg_next  = 1'b1;
            disc_next = sq_reg;
        end
        else
        begin
            disc_next = sq_reg - qq_reg;
        end
    end

    always_comb
    begin
        q6_next     = q5_reg;
        q6_next.neg = neg_next && !q5_reg.para;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg   <= d1_next;
            d2_reg   <= d1_reg;
            gxfy_reg <= d1_reg.gx * d1_reg.fy;
            gyfx_reg <= d1_reg.gy * d1_reg.fx;
            hxgy_reg <= d1_reg.hx * d1_reg.gy;
            hygx_reg <= d1_reg.hy * d1_reg.gx;
            exfy_reg <= d1_reg.ex * d1_reg.fy;
            eyfx_reg <= d1_reg.ey * d1_reg.fx;
            hxey_reg <= d1_reg.hx * d1_reg.ey;
            hyex_reg <= d1_reg.hy * d1_reg.ex;
            q3_reg   <= q3_next;
            q4_reg   <= q4_next;
            sqlo_reg <= mk1 * mk1[SQ_SP-1:0];
            sqhi_reg <= mk1 * mk1[K1_W-1:SQ_SP];
            qlo_reg  <= mk0 * mk2[QQ_SP-1:0];
            qhi_reg  <= mk0 * mk2[K2_W-1:QQ_SP];
            sgn4_reg <= q3_reg.k0[K0_W-1] ^ q3_reg.k2[K2_W-1];
            q5_reg   <= q4_reg;
            sgn5_reg <= sgn4_reg;
            sq_reg   <= sq_next;
            qq_reg   <= qq_next;
            q6_reg   <= q6_next;
            disc_reg <= disc_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign out_quad  = q6_reg;
    assign out_disc  = disc_reg;

endmodule

// File: hw/rtl/ibw_sqrt.sv
// pipelined integer square root, one root bit per stage
module ibw_sqrt
    import ibw_pkg::*;
#(
    parameter type side_t = logic
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  side_t             in_side,
    input  logic [DISC_W-1:0] in_rad,
    output logic              out_valid,
    output side_t             out_side,
    output logic [ROOT_W-1:0] out_root
);
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic              valid_reg [ROOT_W];
    side_t             side_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];

    logic              valid_in  [ROOT_W];
    side_t             side_in   [ROOT_W];
    logic [RAD_W-1:0]  rad_in    [ROOT_W];
    logic [REM_W-1:0]  rem_in    [ROOT_W];
    logic [ROOT_W-1:0] root_in   [ROOT_W];
    logic [REM_W-1:0]  cur       [ROOT_W];
    logic [REM_W-1:0]  trial     [ROOT_W];
    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];

    always_comb
    begin
        valid_in[0] = in_valid;
        side_in[0]  = in_side;
        rad_in[0]   = RAD_W'(in_rad);
        rem_in[0]   = '0;
        root_in[0]  = '0;
        for (int s = 1; s < ROOT_W; s++)
        begin
            valid_in[s] = valid_reg[s-1];
            side_in[s]  = side_reg[s-1];
            rad_in[s]   = rad_reg[s-1];
            rem_in[s]   = rem_reg[s-1];
            root_in[s]  = root_reg[s-1];
        end
        for (int s = 0; s < ROOT_W; s++)
        begin
            cur[s]   = {rem_in[s][REM_W-3:0], rad_in[s][RAD_W-1 -: 2]};
            trial[s] = {1'b0, root_in[s], 2'b01};
            if (cur[s] >= trial[s])
            begin
                rem_next[s]  = cur[s] - trial[s];
                root_next[s] = {root_in[s][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = cur[s];
                root_next[s] = {root_in[s][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < ROOT_W; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int s = 0; s < ROOT_W; s++)
            begin
                valid_reg[s] <= valid_in[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < ROOT_W; s++)
            begin
                side_reg[s] <= side_in[s];
                rad_reg[s]  <= rad_in[s] << 2;
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

// File: hw/rtl/ibw_div.sv
// pipelined rounded saturating Q.14 divider, one quotient bit per core stage
module ibw_div
    import ibw_pkg::*;
#(
    parameter int  NUM_W  = VNUM_W,
    parameter int  DEN_W  = VDEN_W,
    parameter type side_t = logic
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  side_t             in_side,
    input  logic signed [NUM_W-1:0] in_num,
    input  logic signed [DEN_W-1:0] in_den,
    output logic              out_valid,
    output side_t             out_side,
    output coord_t            out_quo,
    output logic              out_zero
);
    localparam int QB  = 18;
    localparam int NRW = NUM_W + FRAC_Q + 2;
    localparam int DRW = DEN_W + QB + 1;
    localparam int RW  = (NRW > DRW) ? NRW : DRW;

    logic             prep_valid_reg;
    side_t            prep_side_reg;
    logic [NUM_W-1:0] nmag_reg;
    logic [DEN_W-1:0] dmag_reg;
    logic             prep_neg_reg;
    logic             prep_zero_reg;

    logic             valid_reg [QB];
    side_t            side_reg  [QB];
    logic [RW-1:0]    rem_reg   [QB];
    logic [DEN_W:0]   dsh_reg   [QB];
    logic [QB-1:0]    q_reg     [QB];
    logic             neg_reg   [QB];
    logic             zero_reg  [QB];

    logic             valid_in  [QB];
    side_t            side_in   [QB];
    logic [RW-1:0]    rem_in    [QB];
    logic [DEN_W:0]   dsh_in    [QB];
    logic [QB-1:0]    q_in      [QB];
    logic             neg_in    [QB];
    logic             zero_in   [QB];
    logic [RW-1:0]    trial     [QB];
    logic [RW-1:0]    rem_next  [QB];
    logic [QB-1:0]    q_next    [QB];

    logic             out_valid_reg;
    side_t            out_side_reg;
    coord_t           quo_reg;
    logic             zero_out_reg;

    always_comb
    begin
        valid_in[0] = prep_valid_reg;
        side_in[0]  = prep_side_reg;
        rem_in[0]   = (RW'(nmag_reg) << (FRAC_Q + 1)) + RW'(dmag_reg);
        dsh_in[0]   = {dmag_reg, 1'b0};
        q_in[0]     = '0;
        neg_in[0]   = prep_neg_reg;
        zero_in[0]  = prep_zero_reg;
        for (int s = 1; s < QB; s++)
        begin
            valid_in[s] = valid_reg[s-1];
            side_in[s]  = side_reg[s-1];
            rem_in[s]   = rem_reg[s-1];
            dsh_in[s]   = dsh_reg[s-1];
            q_in[s]     = q_reg[s-1];
            neg_in[s]   = neg_reg[s-1];
            zero_in[s]  = zero_reg[s-1];
        end
        for (int s = 0; s < QB; s++)
        begin
            trial[s] = RW'(dsh_in[s]) << (QB - 1 - s);
            if (rem_in[s] >= trial[s])
            begin
                rem_next[s] = rem_in[s] - trial[s];
                q_next[s]   = {q_in[s][QB-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = rem_in[s];
                q_next[s]   = {q_in[s][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int s = 0; s < QB; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            prep_valid_reg <= in_valid;
            out_valid_reg  <= valid_reg[QB-1];
            for (int s = 0; s < QB; s++)
            begin
                valid_reg[s] <= valid_in[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_side_reg <= in_side;
            nmag_reg      <= in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
            dmag_reg      <= in_den[DEN_W-1] ? DEN_W'(-in_den) : DEN_W'(in_den);
            prep_neg_reg  <= in_num[NUM_W-1] ^ in_den[DEN_W-1];
            prep_zero_reg <= (in_den == '0);
            for (int s = 0; s < QB; s++)
            begin
                side_reg[s] <= side_in[s];
                rem_reg[s]  <= rem_next[s];
                dsh_reg[s]  <= dsh_in[s];
                q_reg[s]    <= q_next[s];
                neg_reg[s]  <= neg_in[s];
                zero_reg[s] <= zero_in[s];
            end
            out_side_reg <= side_reg[QB-1];
            zero_out_reg <= zero_reg[QB-1];
            quo_reg      <= zero_reg[QB-1] ? '0
                          : sat_q14(neg_reg[QB-1], SAT_MAG_W'(q_reg[QB-1]));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_side  = out_side_reg;
    assign out_quo   = quo_reg;
    assign out_zero  = zero_out_reg;

endmodule

// File: hw/rtl/ibw_weights.sv
// root selection and the four corner weights, three register stages
module ibw_weights
    import ibw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  vpair_t   in_vp,
    input  coord_t   in_ua,
    input  logic     in_za,
    input  coord_t   in_ub,
    input  logic     in_zb,
    output logic     out_valid,
    output ibw_out_t out_data
);
    localparam int F_W = COORD_W + 1;
    localparam int P_W = 2 * F_W;

    logic [2:0] valid_reg;
    coord_t u_next, v_next, u_reg, v_reg, u2_reg, v2_reg;
    logic   dg_next, dg_reg, dg2_reg;
    logic   in_unit;
    logic signed [F_W-1:0] omu, omv;
    logic signed [P_W-1:0] ptl_reg, ptr_reg, pbl_reg, pbr_reg;
    ibw_out_t out_next, out_reg;

    function automatic coord_t round_q14(input logic signed [P_W-1:0] p);
        logic [P_W-1:0] m;
        m = p[P_W-1] ? P_W'(-p) : P_W'(p);
        return sat_q14(p[P_W-1], SAT_MAG_W'((m + P_W'(Q14_ONE / 2)) >> FRAC_Q));
    endfunction

    always_comb
    begin
        in_unit = (in_ua >= 0) && (in_ua <= Q14_ONE) && (in_vp.va >= 0) && (in_vp.va <= Q14_ONE);
        if (in_vp.neg)
        begin
            u_next  = '0;
            v_next  = '0;
            dg_next = 1'b1;
        end
        else if (in_vp.para)
        begin
            u_next  = in_ua;
            v_next  = in_vp.va;
            dg_next = in_vp.vzero | in_za;
        end
        else if (!in_za && in_unit)
        begin
            u_next  = in_ua;
            v_next  = in_vp.va;
            dg_next = 1'b0;
        end
        else
        begin
            u_next  = in_ub;
            v_next  = in_vp.vb;
            dg_next = in_zb;
        end
    end

    always_comb
    begin
        omu = F_W'(Q14_ONE) - F_W'(u_reg);
        omv = F_W'(Q14_ONE) - F_W'(v_reg);
    end

    always_comb
    begin
        out_next.weight_u       = u2_reg;
        out_next.weight_v       = v2_reg;
        out_next.w_top_left     = round_q14(ptl_reg);
        out_next.w_top_right    = round_q14(ptr_reg);
        out_next.w_bottom_left  = round_q14(pbl_reg);
        out_next.w_bottom_right = round_q14(pbr_reg);
        out_next.degenerate     = dg2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg   <= u_next;
            v_reg   <= v_next;
            dg_reg  <= dg_next;
            ptl_reg <= omu * omv;
            ptr_reg <= u_reg * omv;
            pbl_reg <= v_reg * omu;
            pbr_reg <= u_reg * v_reg;
            u2_reg  <= u_reg;
            v2_reg  <= v_reg;
            dg2_reg <= dg_reg;
            out_reg <= out_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = out_reg;

endmodule
